// ===== design/dxt_pkg.sv =====
// shared constants, types and endpoint widening functions for the dxt block decoder
package dxt_pkg;

  // stream widths: a 128-bit compressed block in, a 40-bit pixel beat out
  localparam int InW  = 128;
  localparam int OutW = 40;

  // one rgb triple, red in element 0
  typedef logic [2:0][7:0] rgb_t;

  // reciprocal multipliers for the fixed divisions, with matching shifts
  localparam logic [9:0]  Recip3 = 10'd683;   // x/3 for x below 766
  localparam logic [10:0] Recip5 = 11'd1639;  // x/5 for x below 1276
  localparam logic [11:0] Recip7 = 12'd2341;  // x/7 for x below 1786

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaClear  = 8'd0;
  localparam logic [3:0] LastPixel   = 4'd15;

  // five-bit channel to eight bits, floor(v*255/31) = 8v + floor(7v/31)
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [2:0] q;
    q = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
      + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v == 5'd31);
    return {v, 3'b000} + {5'b00000, q};
  endfunction

  // six-bit channel to eight bits, floor(v*255/63) = 4v + floor(v/21)
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] q;
    q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v == 6'd63);
    return {v, 2'b00} + {6'b000000, q};
  endfunction

endpackage

// ===== design/dxt_block_texture_decoder.sv =====
// dxt1 / dxt5 4x4 block decoder: palette pipeline and pixel serializer
//
//   channel   dir  beat                        fields
//   s_axis    in   one compressed block        tdata: color_word, alpha_word
//   m_axis    out  one decoded pixel           tdata: rgba, pixel_index; tlast
//   cfg       in   format_mode write           cfg_wdata, taken when cfg_we
//
// a block passes three palette stages (widen and sums, reciprocal multiplies,
// palette select), then a serializer emits its 16 pixels through an output
// register, one per cycle while m_axis takes them; the serializer takes the
// next block as its last pixel goes out, and up to three blocks wait in the
// stages while it drains one.
// rst is synchronous and clears all valid bits and format_mode (dxt1).
// back pressure on m_axis holds every full stage in place, nothing lost or repeated.
module dxt_block_texture_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [63:0] color_word, [127:64] alpha_word
  input  logic [dxt_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [35:32] pixel_index, [39:36] zero
  output logic [dxt_pkg::OutW-1:0]  m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata
);
  import dxt_pkg::*;

  // configuration
  logic format_mode;

  // input decode
  logic [63:0] cw, aw;
  logic [15:0] c0, c1;
  logic [7:0]  a0, a1;
  rgb_t        e0_in, e1_in, mid_in;
  logic [2:0][9:0]  n2_in, n3_in;
  logic [5:0][10:0] x7_in;
  logic [3:0][10:0] x5_in;

  // stage a: widened endpoints and numerators
  logic             a_valid;
  rgb_t             a_e0, a_e1, a_mid;
  logic [2:0][9:0]  a_n2, a_n3;
  logic             a_cgt, a_agt;
  logic [31:0]      a_cidx;
  logic [47:0]      a_aidx;
  logic [7:0]       a_a0, a_a1;
  logic [5:0][10:0] a_x7;
  logic [3:0][10:0] a_x5;

  // stage b: reciprocal products
  logic             b_valid;
  rgb_t             b_e0, b_e1, b_mid;
  logic [2:0][19:0] b_p2, b_p3;
  logic             b_cgt, b_agt;
  logic [31:0]      b_cidx;
  logic [47:0]      b_aidx;
  logic [7:0]       b_a0, b_a1;
  logic [5:0][22:0] b_p7;
  logic [3:0][21:0] b_p5;

  // stage c: finished palettes
  logic            c_valid;
  rgb_t            c_cpal [4];
  logic [7:0]      c_apal [8];
  logic            c_cgt;
  logic [31:0]     c_cidx;
  logic [47:0]     c_aidx;

  // serializer holding one block
  logic            ser_valid;
  logic [3:0]      ser_cnt;
  rgb_t            ser_cpal [4];
  logic [7:0]      ser_apal [8];
  logic            ser_cgt;
  logic [31:0]     ser_cidx;
  logic [47:0]     ser_aidx;

  // output register
  logic            out_valid;
  logic [OutW-1:0] out_data;
  logic            out_last;

  // handshake chain
  logic out_load, ser_done, ser_ready, ser_load, c_ready, b_ready, a_ready;

  // per-pixel select
  logic [1:0] ci;
  logic [5:0] apos;
  logic [2:0] ai;
  logic [7:0] pix_alpha;
  rgb_t       pix_rgb;

  // ready flows back, a stage moves when its successor is empty or moving
  assign out_load      = ser_valid && (!out_valid || m_axis_tready);
  assign ser_done      = out_load && (ser_cnt == LastPixel);
  assign ser_ready     = !ser_valid || ser_done;
  assign ser_load      = ser_ready && c_valid;
  assign c_ready       = !c_valid || ser_ready;
  assign b_ready       = !b_valid || c_ready;
  assign a_ready       = !a_valid || b_ready;
  assign s_axis_tready = a_ready;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= 1'b0;
    end else if (cfg_we) begin
      format_mode <= cfg_wdata;
    end
  end

  // widen endpoints and form the interpolation numerators
  always_comb begin
    cw = s_axis_tdata[63:0];
    aw = s_axis_tdata[127:64];
    c0 = cw[15:0];
    c1 = cw[31:16];
    a0 = aw[7:0];
    a1 = aw[15:8];
    e0_in[0] = widen5(c0[15:11]);
    e0_in[1] = widen6(c0[10:5]);
    e0_in[2] = widen5(c0[4:0]);
    e1_in[0] = widen5(c1[15:11]);
    e1_in[1] = widen6(c1[10:5]);
    e1_in[2] = widen5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      n2_in[ch]  = {1'b0, e0_in[ch], 1'b0} + {2'b00, e1_in[ch]};
      n3_in[ch]  = {2'b00, e0_in[ch]} + {1'b0, e1_in[ch], 1'b0};
      mid_in[ch] = 8'(({1'b0, e0_in[ch]} + {1'b0, e1_in[ch]}) >> 1);
    end
    for (int i = 0; i < 6; i++) begin
      x7_in[i] = {3'b000, a0} * 11'(6 - i) + {3'b000, a1} * 11'(i + 1);
    end
    for (int i = 0; i < 4; i++) begin
      x5_in[i] = {3'b000, a0} * 11'(4 - i) + {3'b000, a1} * 11'(i + 1);
    end
  end

  // stage a register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_e0   <= e0_in;
      a_e1   <= e1_in;
      a_mid  <= mid_in;
      a_n2   <= n2_in;
      a_n3   <= n3_in;
      a_cgt  <= c0 > c1;
      a_agt  <= a0 > a1;
      a_cidx <= cw[63:32];
      a_aidx <= aw[63:16];
      a_a0   <= a0;
      a_a1   <= a1;
      a_x7   <= x7_in;
      a_x5   <= x5_in;
    end
  end

  // stage b: reciprocal multiplies for every interpolated entry, both alpha styles
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_e0   <= a_e0;
      b_e1   <= a_e1;
      b_mid  <= a_mid;
      b_cgt  <= a_cgt;
      b_agt  <= a_agt;
      b_cidx <= a_cidx;
      b_aidx <= a_aidx;
      b_a0   <= a_a0;
      b_a1   <= a_a1;
      for (int ch = 0; ch < 3; ch++) begin
        b_p2[ch] <= {10'd0, a_n2[ch]} * {10'd0, Recip3};
        b_p3[ch] <= {10'd0, a_n3[ch]} * {10'd0, Recip3};
      end
      for (int i = 0; i < 6; i++) begin
        b_p7[i] <= {12'd0, a_x7[i]} * {11'd0, Recip7};
      end
      for (int i = 0; i < 4; i++) begin
        b_p5[i] <= {11'd0, a_x5[i]} * {11'd0, Recip5};
      end
    end
  end

  // stage c: pick palette entries by the endpoint order tests
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_cgt     <= b_cgt;
      c_cidx    <= b_cidx;
      c_aidx    <= b_aidx;
      c_cpal[0] <= b_e0;
      c_cpal[1] <= b_e1;
      for (int ch = 0; ch < 3; ch++) begin
        c_cpal[2][ch] <= b_cgt ? b_p2[ch][18:11] : b_mid[ch];
        c_cpal[3][ch] <= b_cgt ? b_p3[ch][18:11] : 8'd0;
      end
      c_apal[0] <= b_a0;
      c_apal[1] <= b_a1;
      if (b_agt) begin
        for (int i = 0; i < 6; i++) begin
          c_apal[i+2] <= b_p7[i][21:14];
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          c_apal[i+2] <= b_p5[i][20:13];
        end
        c_apal[6] <= AlphaClear;
        c_apal[7] <= AlphaOpaque;
      end
    end
  end

  // serializer: holds a block and steps through its pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= 4'd0;
    end else if (ser_ready) begin
      ser_valid <= c_valid;
      ser_cnt   <= 4'd0;
    end else if (out_load) begin
      ser_cnt <= ser_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready) begin
      ser_cpal <= c_cpal;
      ser_apal <= c_apal;
      ser_cgt  <= c_cgt;
      ser_cidx <= c_cidx;
      ser_aidx <= c_aidx;
    end
  end

  // current pixel lookup
  always_comb begin
    ci      = ser_cidx[{ser_cnt, 1'b0} +: 2];
    apos    = {2'b00, ser_cnt} + {1'b0, ser_cnt, 1'b0};
    ai      = ser_aidx[apos +: 3];
    pix_rgb = ser_cpal[ci];
    if (format_mode) begin
      pix_alpha = ser_apal[ai];
    end else if (ci == 2'd3 && !ser_cgt) begin
      pix_alpha = AlphaClear;
    end else begin
      pix_alpha = AlphaOpaque;
    end
  end

  // output register, refilled in the cycle its beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'b0000, ser_cnt, pix_alpha, pix_rgb[2], pix_rgb[1], pix_rgb[0]};
      out_last <= ser_cnt == LastPixel;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // tlast marks exactly the sixteenth pixel
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[35:32] == LastPixel)))
    else $error("tlast does not match pixel index");

  // a taken pixel that is not the last is followed at once by the next one
  a_pixel_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[35:32] == $past(m_axis_tdata[35:32]) + 4'd1))
    else $error("pixel sequence broken");

  // a freshly loaded block starts at pixel zero
  a_ser_start: assert property (@(posedge clk) disable iff (rst)
    ser_load |=> (ser_valid && ser_cnt == 4'd0))
    else $error("serializer did not restart");

  // a palette waiting on a busy serializer stays put
  a_c_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !ser_ready) |=> (c_valid && $stable(c_cidx) && $stable(c_aidx)))
    else $error("stage c lost its block while stalled");

endmodule

// ===== bench/dxt_pixel_checker.sv =====
// pixel checker for the dxt block decoder: predicts each block's 16 pixels and compares beats
module dxt_pixel_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  // [63:0] color_word, [127:64] alpha_word
  input  logic [dxt_pkg::InW-1:0]  s_axis_tdata,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [35:32] pixel_index, [39:36] zero
  input  logic [dxt_pkg::OutW-1:0] m_axis_tdata,
  input  logic                     m_axis_tlast,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  output int                       mismatches,
  output int                       pending,
  output int                       pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dxt_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pixel_index;
    logic       last_pixel;
  } pixel_t;

  pixel_t expected_pixels[$];
  logic   format_mode;
  int     errors;

  initial begin
    errors         = 0;
    mismatches     = 0;
    pending        = 0;
    pixels_checked = 0;
    format_mode    = 1'b0;
  end

  // scale an n-bit channel up to 8 bits, rounding down
  function automatic int scale_channel(input int v, input int full);
    return v * 255 / full;
  endfunction

  // build the colour and alpha palettes of one block and queue its pixels
  task automatic decode_block(input logic [63:0] cw, input logic [63:0] aw);
    int     c0;
    int     c1;
    int     a0;
    int     a1;
    int     ci;
    int     ai;
    int     pal[4][4];
    int     apal[8];
    pixel_t px;
    c0 = int'(cw[15:0]);
    c1 = int'(cw[31:16]);
    pal[0][0] = scale_channel((c0 >> 11) & 31, 31);
    pal[0][1] = scale_channel((c0 >> 5) & 63, 63);
    pal[0][2] = scale_channel(c0 & 31, 31);
    pal[1][0] = scale_channel((c1 >> 11) & 31, 31);
    pal[1][1] = scale_channel((c1 >> 5) & 63, 63);
    pal[1][2] = scale_channel(c1 & 31, 31);
    pal[0][3] = 255;
    pal[1][3] = 255;
    // four-colour block when c0 > c1, else midpoint plus transparent black
    for (int ch = 0; ch < 3; ch++) begin
      if (c0 > c1) begin
        pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
        pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
      end else begin
        pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
        pal[3][ch] = 0;
      end
    end
    pal[2][3] = 255;
    pal[3][3] = (c0 > c1) ? 255 : 0;
    // alpha palette: seventh steps, or fifth steps with 0 and 255 at the end
    a0 = int'(aw[7:0]);
    a1 = int'(aw[15:8]);
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
    end else begin
      for (int i = 1; i <= 4; i++) apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    // raster order, pixel 0 in the lowest index bits
    for (int k = 0; k < 16; k++) begin
      ci = int'((cw >> (32 + 2 * k)) & 64'd3);
      ai = int'((aw >> (16 + 3 * k)) & 64'd7);
      px.red         = 8'(pal[ci][0]);
      px.green       = 8'(pal[ci][1]);
      px.blue        = 8'(pal[ci][2]);
      px.alpha       = format_mode ? 8'(apal[ai]) : 8'(pal[ci][3]);
      px.pixel_index = 4'(k);
      px.last_pixel  = (k == 15);
      expected_pixels = {expected_pixels, px};
    end
  endtask

  // track the mode register, queue predictions, check output beats
  always @(posedge clk) begin
    pixel_t want;
    logic   bad;
    if (rst) begin
      format_mode <= 1'b0;
    end else begin
      if (cfg_we) format_mode <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        decode_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_checked <= pixels_checked + 1;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("unexpected pixel beat: data=%h last=%b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_pixels.pop_front();
          bad  = (m_axis_tdata[7:0] !== want.red) || (m_axis_tdata[15:8] !== want.green)
              || (m_axis_tdata[23:16] !== want.blue) || (m_axis_tdata[31:24] !== want.alpha)
              || (m_axis_tdata[35:32] !== want.pixel_index)
              || (m_axis_tdata[OutW-1:36] !== '0) || (m_axis_tlast !== want.last_pixel);
          if (bad) begin
            errors++;
            if (errors <= ReportLimit) begin
              $display("pixel mismatch, expected r=%h g=%h b=%h a=%h idx=%0d last=%b",
                       want.red, want.green, want.blue, want.alpha,
                       want.pixel_index, want.last_pixel);
              $display("                got      r=%h g=%h b=%h a=%h idx=%0d last=%b pad=%h",
                       m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[31:24], m_axis_tdata[35:32], m_axis_tlast,
                       m_axis_tdata[OutW-1:36]);
            end
          end
        end
      end
    end
    mismatches <= errors;
    pending    <= expected_pixels.size();
  end

endmodule

// ===== bench/dxt_block_texture_decoder_tb.sv =====
// testbench top for the dxt block decoder: stimulus, stalls, mode phases and verdict
module dxt_block_texture_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dxt_pkg::*;

  localparam logic ModeDxt1     = 1'b0;
  localparam logic ModeDxt5     = 1'b1;
  localparam int   QuietLimit   = 2000;
  localparam int   SettleCycles = 12;
  localparam int   IdlePercent  = 21;

  logic            clk           = 1'b0;
  logic            rst           = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tlast;
  logic            cfg_we        = 1'b0;
  logic            cfg_wdata     = 1'b0;

  logic idle_on     = 1'b1;
  int   blocks_sent = 0;
  int   quiet       = 0;
  int   mismatches;
  int   pending;
  int   pixels_checked;

  dxt_block_texture_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  dxt_pixel_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pixel sink back pressure
  always @(negedge clk) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= IdlePercent);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d pixels still due", quiet, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one block, with a random gap first; returns at a falling edge
  task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {aw, cw};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    blocks_sent++;
  endtask

  // stop sending and wait for every predicted pixel to come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // mode register write, only with the block empty
  task automatic set_mode(input logic mode);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // random block, often with tied or extreme endpoints
  function automatic logic [127:0] random_block();
    logic [63:0] cw;
    logic [63:0] aw;
    cw = {$urandom, $urandom};
    aw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: cw[31:16] = cw[15:0];
      1: cw[15:0]  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2: cw[31:16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      3: aw[15:8]  = aw[7:0];
      4: aw[7:0]   = $urandom_range(1) ? 8'hFF : 8'h00;
      5: aw[15:8]  = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return {aw, cw};
  endfunction

  task automatic send_random(input int count, input int pause_at);
    logic [127:0] blk;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      blk = random_block();
      send_block(blk[63:0], blk[127:64]);
    end
  endtask

  // indices 0..7 repeated, for the alpha word bits 63:16
  localparam logic [47:0] AlphaRamp = 48'hFAC688_FAC688;

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, colour only
    set_mode(ModeDxt1);
    send_block(64'h0, 64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'h0);
    send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'h1B1B_1B1B, 16'h0000, 16'h0001}, 64'h0);
    send_block({32'hE4E4_E4E4, 16'h07E0, 16'hF800}, 64'h0);
    send_block({32'h4E4E_4E4E, 16'hF81F, 16'h001F}, 64'h0);
    send_block({32'hFFFF_FFFF, 16'h1234, 16'h1234}, 64'h0);
    send_block({32'hAAAA_5555, 16'h8410, 16'h7BEF}, 64'h0);

    // directed, interpolated alpha
    set_mode(ModeDxt5);
    send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'h0);
    send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, {AlphaRamp, 8'h00, 8'hFF});
    send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, {AlphaRamp, 8'hFF, 8'h00});
    send_block({32'hFFFF_FFFF, 16'h0000, 16'h0000}, {AlphaRamp, 8'h80, 8'h80});
    send_block({32'h1B1B_1B1B, 16'h0000, 16'h0001}, {AlphaRamp, 8'h40, 8'h41});
    send_block({32'hE4E4_E4E4, 16'hF800, 16'h07E0}, {AlphaRamp, 8'h41, 8'h40});
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h0, {AlphaRamp, 8'h00, 8'h00});
    send_block({32'h4E4E_4E4E, 16'h1234, 16'h5678}, {AlphaRamp, 8'h13, 8'hC7});

    // random phases; one pause for a full drain in the first
    send_random(150, 75);
    set_mode(ModeDxt1);
    send_random(150, -1);
    set_mode(ModeDxt5);
    idle_on = 1'b0;
    send_random(80, -1);
    set_mode(ModeDxt1);
    idle_on = 1'b1;
    send_random(70, -1);

    drain();
    $display("%0d blocks sent, %0d pixel beats checked: dxt1 and dxt5, both palette styles,",
             blocks_sent, pixels_checked);
    $display("tied and extreme endpoints, random stalls on both sides and one stall-free run");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
